// ===== rtl/core/cdd_pkg.sv =====
// shared types, constants and helper functions for the calendar day difference block
package cdd_pkg;

  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int MdayW  = 5;
  localparam int CountW = 23;
  localparam int DiffW  = 23;

  typedef logic [YearW-1:0]         year_t;
  typedef logic [MonthW-1:0]        month_t;
  typedef logic [MdayW-1:0]         mday_t;
  typedef logic [CountW-1:0]        count_t;
  typedef logic signed [DiffW-1:0]  diff_t;

  // saturation limits of the signed result
  localparam logic [DiffW-1:0] DIFF_MAX = 23'h3FFFFF;
  localparam logic [DiffW-1:0] DIFF_MIN = 23'h400000;

  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  // 1311 / 2^15 approximates 1/25 closely enough for quotients of 12-bit values
  localparam logic [10:0] RECIP_25      = 11'd1311;

  // floor(x / 25) for any 12-bit x
  function automatic logic [7:0] div25(input logic [11:0] x);
    logic [22:0] prod;
    prod = 23'(x) * 23'(RECIP_25);
    return prod[22:15];
  endfunction

  // days in the months before the given month; month zero is January,
  // months above twelve are December
  function automatic logic [8:0] days_before_month(input month_t m);
    logic [8:0] days;
    case (m) inside
      4'd0, 4'd1:          days = 9'd0;
      4'd2:                days = 9'd31;
      4'd3:                days = 9'd59;
      4'd4:                days = 9'd90;
      4'd5:                days = 9'd120;
      4'd6:                days = 9'd151;
      4'd7:                days = 9'd181;
      4'd8:                days = 9'd212;
      4'd9:                days = 9'd243;
      4'd10:               days = 9'd273;
      4'd11:               days = 9'd304;
      default:             days = 9'd334;
    endcase
    return days;
  endfunction

endpackage

// ===== rtl/core/calendar_day_difference.sv =====
// top level: input register, two day counts, saturating subtract, result register
//
// Signed number of days from a first calendar date to a second one.
// Input channel: in_valid / in_ready with the two dates as six fields.
// Output channel: out_valid / out_ready with day_difference, two's complement,
// saturated to the 23-bit range.
// The pair is captured in an input register; the day counts and the
// subtraction are combinational between that register and the result
// register. out_valid rises when the result register takes the pair from the
// input register, so the result passes two register stages end to end,
// and one pair is taken every cycle while the receiver keeps up.
// When the receiver stalls the result register holds its item and the
// input register can still fill, so one more pair is taken; after that
// in_ready drops until out_ready returns.
// Reset empties both stages; nothing is offered until a new transfer.
module calendar_day_difference (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cdd_pkg::year_t  first_year,
  input  cdd_pkg::month_t first_month,
  input  cdd_pkg::mday_t  first_day,
  input  cdd_pkg::year_t  second_year,
  input  cdd_pkg::month_t second_month,
  input  cdd_pkg::mday_t  second_day,
  output logic            out_valid,
  input  logic            out_ready,
  output cdd_pkg::diff_t  day_difference
);
  import cdd_pkg::*;

  logic   s1_valid;
  year_t  hold_first_year;
  month_t hold_first_month;
  mday_t  hold_first_day;
  year_t  hold_second_year;
  month_t hold_second_month;
  mday_t  hold_second_day;
  logic   s2_load;
  count_t count_first;
  count_t count_second;
  logic [23:0]      raw_diff;
  logic [DiffW-1:0] diff_next;

  // stage handshake
  assign s2_load  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s2_load;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_first_year   <= first_year;
      hold_first_month  <= first_month;
      hold_first_day    <= first_day;
      hold_second_year  <= second_year;
      hold_second_month <= second_month;
      hold_second_day   <= second_day;
    end
  end

  // day counts of both dates
  cdd_day_count u_count_first (
    .year  (hold_first_year),
    .month (hold_first_month),
    .day   (hold_first_day),
    .count (count_first)
  );

  cdd_day_count u_count_second (
    .year  (hold_second_year),
    .month (hold_second_month),
    .day   (hold_second_day),
    .count (count_second)
  );

  // subtract and saturate to the result width
  assign raw_diff = {1'b0, count_second} - {1'b0, count_first};
  always_comb begin
    if (raw_diff[23] != raw_diff[22]) begin
      diff_next = raw_diff[23] ? DIFF_MIN : DIFF_MAX;
    end else begin
      diff_next = raw_diff[22:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      day_difference <= diff_t'(diff_next);
    end
  end

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!s1_valid && !out_valid))
    else $error("pipeline not empty after reset");

  // an input transfer always lands in the input register
  a_capture: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("input transfer lost");

  // a stalled result keeps the input stage and its payload in place
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=>
      (s1_valid && $stable(hold_first_year) && $stable(hold_second_year)))
    else $error("input stage changed under a stall");

  // a loaded stage always produces a result
  a_advance: assert property (@(posedge clk) disable iff (rst)
    s2_load |=> out_valid)
    else $error("result not offered after stage advance");

endmodule

// ===== rtl/core/cdd_day_count.sv =====
// absolute day count of one calendar date
module cdd_day_count (
  input  cdd_pkg::year_t  year,
  input  cdd_pkg::month_t month,
  input  cdd_pkg::mday_t  day,
  output cdd_pkg::count_t count
);
  import cdd_pkg::*;

  logic        div4;
  logic [7:0]  cent_y;
  logic [12:0] cent_y_x25;
  logic        div100;
  logic        div400;
  logic        div3200;
  logic        leap;
  year_t       prev_year;
  logic [7:0]  cent_n;
  logic [11:0] leaps;
  logic [8:0]  doy;
  logic [22:0] year_days;

  // leap rule on the year itself: quotient by 100 via floor(floor(y/4)/25)
  assign div4       = (year[1:0] == 2'b00);
  assign cent_y     = div25(year[13:2]);
  assign cent_y_x25 = 13'({cent_y, 4'b0000}) + 13'({cent_y, 3'b000}) + 13'(cent_y);
  assign div100     = div4 && (cent_y_x25 == 13'(year[13:2]));
  assign div400     = div100 && (cent_y[1:0] == 2'b00);
  assign div3200    = div100 && (cent_y[4:0] == 5'b00000);
  assign leap       = ((div4 && !div100) || div400) && !div3200;

  // leap years before this one: n/4 - n/100 + n/400 - n/3200 with n = year - 1
  assign prev_year = year - 14'd1;
  assign cent_n    = div25(prev_year[13:2]);
  always_comb begin
    if (year == '0) begin
      leaps = '0;
    end else begin
      leaps = prev_year[13:2] - 12'(cent_n) + 12'(cent_n[7:2]) - 12'(cent_n[7:5]);
    end
  end

  // day of year, one extra after february in a leap year
  assign doy = days_before_month(month) + 9'(leap && (month > 4'd2)) + 9'(day);

  assign year_days = 23'(year) * 23'(DAYS_PER_YEAR);
  assign count     = year_days + 23'(leaps) + 23'(doy);

endmodule
